// ----- rtl/fla_pkg.sv -----
// Shared constants and types of the free-list heap allocator.
package fla_pkg;

    localparam int ALIGN_BYTES    = 16;
    localparam int NODE_BYTES     = 16;
    localparam int FREE_SLOTS_DEF = 32;
    localparam int USED_SLOTS_DEF = 64;

    localparam logic [31:0] HEAP_RESET = 32'd1048576;
    localparam logic [31:0] HEAP_MIN   = 32'd32;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_HEAP   = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_OUT,
        DP_OK0,
        DP_FAIL1,
        DP_FAIL2,
        DP_FAIL3,
        DP_FRD,
        DP_FIT,
        DP_GRANT,
        DP_URD,
        DP_UCHK,
        DP_PCHK,
        DP_MERGE,
        DP_RRD,
        DP_RWR,
        DP_RDONE,
        DP_IRD,
        DP_IWR,
        DP_IFIN
    } dp_cmd_t;

    typedef struct packed {
        logic init_busy;
        logic is_free;
        logic addr_zero;
        logic slot_free;
        logic idx_end;
        logic pick_stop;
        logic has_pick;
        logic split;
        logic used_end;
        logic used_hit;
        logic pos_hit;
        logic mnext;
        logic mprev;
        logic full;
        logic rm_end;
        logic ins_end;
    } dp_stat_t;

endpackage

// ----- rtl/fla_ctrl.sv -----
// Sequencer of the free-list heap allocator.
module fla_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  fla_pkg::dp_stat_t stat,
    output fla_pkg::dp_cmd_t  cmd
);
    import fla_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_DISP  = 15'b000000000000010,
        S_FRD   = 15'b000000000000100,
        S_FCMP  = 15'b000000000001000,
        S_AEND  = 15'b000000000010000,
        S_URD   = 15'b000000000100000,
        S_UCMP  = 15'b000000001000000,
        S_PRD   = 15'b000000010000000,
        S_PCMP  = 15'b000000100000000,
        S_MERGE = 15'b000001000000000,
        S_RRD   = 15'b000010000000000,
        S_RWR   = 15'b000100000000000,
        S_IRD   = 15'b001000000000000,
        S_IWR   = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && !stat.init_busy;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = DP_NOP;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && !stat.init_busy) begin
                    cmd        = DP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (stat.is_free) begin
                    if (stat.addr_zero) begin
                        cmd        = DP_OK0;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_URD;
                    end
                end else if (!stat.slot_free) begin
                    cmd        = DP_FAIL1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_FRD;
                end
            end
            S_FRD: begin
                if (stat.idx_end) begin
                    state_next = S_AEND;
                end else begin
                    cmd        = DP_FRD;
                    state_next = S_FCMP;
                end
            end
            S_FCMP: begin
                cmd        = DP_FIT;
                state_next = stat.pick_stop ? S_AEND : S_FRD;
            end
            S_AEND: begin
                if (!stat.has_pick) begin
                    cmd        = DP_FAIL1;
                    state_next = S_DONE;
                end else begin
                    cmd        = DP_GRANT;
                    state_next = stat.split ? S_DONE : S_RRD;
                end
            end
            S_URD: begin
                if (stat.used_end) begin
                    cmd        = DP_FAIL3;
                    state_next = S_DONE;
                end else begin
                    cmd        = DP_URD;
                    state_next = S_UCMP;
                end
            end
            S_UCMP: begin
                cmd        = DP_UCHK;
                state_next = stat.used_hit ? S_PRD : S_URD;
            end
            S_PRD: begin
                if (stat.idx_end) begin
                    state_next = S_MERGE;
                end else begin
                    cmd        = DP_FRD;
                    state_next = S_PCMP;
                end
            end
            S_PCMP: begin
                cmd        = DP_PCHK;
                state_next = stat.pos_hit ? S_MERGE : S_PRD;
            end
            S_MERGE: begin
                if (!stat.mnext && !stat.mprev && stat.full) begin
                    cmd        = DP_FAIL2;
                    state_next = S_DONE;
                end else begin
                    cmd = DP_MERGE;
                    if (stat.mnext && stat.mprev) begin
                        state_next = S_RRD;
                    end else if (!stat.mnext && !stat.mprev) begin
                        state_next = S_IRD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RRD: begin
                if (stat.rm_end) begin
                    cmd        = DP_RDONE;
                    state_next = S_DONE;
                end else begin
                    cmd        = DP_RRD;
                    state_next = S_RWR;
                end
            end
            S_RWR: begin
                cmd        = DP_RWR;
                state_next = S_RRD;
            end
            S_IRD: begin
                if (stat.ins_end) begin
                    cmd        = DP_IFIN;
                    state_next = S_DONE;
                end else begin
                    cmd        = DP_IRD;
                    state_next = S_IWR;
                end
            end
            S_IWR: begin
                cmd        = DP_IWR;
                state_next = S_IRD;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd          = DP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- rtl/fla_dp.sv -----
// Datapath of the free-list heap allocator: tables, scan registers and results.
module fla_dp #(
    parameter int FREE_SLOTS = fla_pkg::FREE_SLOTS_DEF,
    parameter int USED_SLOTS = fla_pkg::USED_SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic [31:0]       cfg_wdata,
    input  logic              s_op,
    input  logic [31:0]       s_request_bytes,
    input  logic [31:0]       s_address,
    input  fla_pkg::dp_cmd_t  cmd,
    output fla_pkg::dp_stat_t stat,
    output logic [1:0]        m_status,
    output logic [31:0]       m_address_out,
    output logic [31:0]       m_granted_bytes
);
    import fla_pkg::*;

    localparam int FA = $clog2(FREE_SLOTS);
    localparam int CW = FA + 1;
    localparam int UA = $clog2(USED_SLOTS);
    localparam int UW = UA + 1;
    localparam logic [32:0] ALIGN_MASK = 33'(ALIGN_BYTES - 1);
    localparam logic [31:0] HDR        = 32'(ALIGN_BYTES);

    // free table and used table
    logic [31:0] free_off_mem [FREE_SLOTS];
    logic [31:0] free_sz_mem  [FREE_SLOTS];
    logic [31:0] used_off_mem [USED_SLOTS];
    logic [31:0] used_sz_mem  [USED_SLOTS];

    logic                  policy_reg;
    logic [31:0]           heap_reg;
    logic                  init_pend_reg;
    logic [CW-1:0]         count_reg;
    logic [USED_SLOTS-1:0] valid_reg;

    logic          op_reg;
    logic [31:0]   addr_reg;
    logic [32:0]   need_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] k_reg;
    logic [FA-1:0] pick_idx_reg;
    logic [31:0]   pick_off_reg, pick_sz_reg;
    logic [32:0]   best_reg;
    logic          has_pick_reg;
    logic [UW-1:0] j_reg;
    logic [UA-1:0] slot_reg;
    logic [31:0]   nsz_reg;
    logic          next_vld_reg;
    logic [31:0]   next_off_reg, next_sz_reg;
    logic [31:0]   prev_off_reg, prev_sz_reg;
    logic [31:0]   rd_off_reg, rd_sz_reg;
    logic [31:0]   ur_off_reg, ur_sz_reg;
    logic [1:0]    res_status_reg;
    logic [31:0]   res_addr_reg, res_grant_reg;
    logic [1:0]    out_status_reg;
    logic [31:0]   out_addr_reg, out_grant_reg;

    logic          heap_wr;
    logic [31:0]   heap_val;
    logic [32:0]   need_in;
    logic [32:0]   diff;
    logic          fit;
    logic          split;
    logic [UA-1:0] free_slot;
    logic          noff_ok;
    logic [31:0]   noff;
    logic          mnext, mprev;
    logic [31:0]   merged_sz;
    logic [31:0]   grant;

    logic          fw_en;
    logic [FA-1:0] fw_idx;
    logic [31:0]   fw_off, fw_sz;
    logic          fr_en;
    logic [FA-1:0] fr_idx;

    assign heap_wr  = cfg_wr_en && (cfg_addr == CFG_HEAP);
    assign heap_val = (cfg_wdata < HEAP_MIN) ? HEAP_MIN : cfg_wdata;
    assign need_in  = ({1'b0, s_request_bytes} + ALIGN_MASK) & ~ALIGN_MASK;
    assign diff     = {1'b0, rd_sz_reg} - need_reg;
    assign fit      = {1'b0, rd_sz_reg} >= need_reg;
    assign split    = {2'b0, pick_sz_reg} >= ({1'b0, need_reg} + 34'(NODE_BYTES + 1));
    assign grant    = split ? need_reg[31:0] : pick_sz_reg;
    assign noff_ok  = addr_reg >= HDR;
    assign noff     = addr_reg - HDR;
    // the freed block ends where its payload ends: address plus size
    assign mnext    = next_vld_reg &&
                      ({2'b0, addr_reg} + {2'b0, nsz_reg}) == {2'b0, next_off_reg};
    assign mprev    = (idx_reg != '0) && noff_ok &&
                      ({2'b0, prev_off_reg} + 34'(ALIGN_BYTES) + {2'b0, prev_sz_reg})
                      == {2'b0, noff};
    assign merged_sz = mnext ? (nsz_reg + HDR + next_sz_reg) : nsz_reg;

    always_comb begin
        free_slot = '0;
        for (int i = USED_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_slot = UA'(i);
            end
        end
    end

    always_comb begin
        stat.init_busy = init_pend_reg;
        stat.is_free   = (op_reg == OP_FREE);
        stat.addr_zero = (addr_reg == '0);
        stat.slot_free = ~&valid_reg;
        stat.idx_end   = idx_reg >= count_reg;
        stat.pick_stop = fit && (!policy_reg || diff == '0);
        stat.has_pick  = has_pick_reg;
        stat.split     = split;
        stat.used_end  = (j_reg == UW'(USED_SLOTS));
        stat.used_hit  = valid_reg[j_reg[UA-1:0]] && (ur_off_reg == addr_reg);
        stat.pos_hit   = noff_ok && (rd_off_reg > noff);
        stat.mnext     = mnext;
        stat.mprev     = mprev;
        stat.full      = count_reg >= CW'(FREE_SLOTS);
        stat.rm_end    = (k_reg + 1'b1) >= count_reg;
        stat.ins_end   = (k_reg == idx_reg);
    end

    // free table port selection
    always_comb begin
        fw_en  = 1'b0;
        fw_idx = '0;
        fw_off = '0;
        fw_sz  = '0;
        fr_en  = 1'b0;
        fr_idx = '0;
        if (init_pend_reg) begin
            fw_en = 1'b1;
            fw_sz = heap_reg - HDR;
        end
        unique case (cmd)
            DP_FRD: begin
                fr_en  = 1'b1;
                fr_idx = idx_reg[FA-1:0];
            end
            DP_GRANT: begin
                fw_en  = split;
                fw_idx = pick_idx_reg;
                fw_off = pick_off_reg + HDR + need_reg[31:0];
                fw_sz  = pick_sz_reg - HDR - need_reg[31:0];
            end
            DP_MERGE: begin
                if (mprev) begin
                    fw_en  = 1'b1;
                    fw_idx = FA'(idx_reg - 1'b1);
                    fw_off = prev_off_reg;
                    fw_sz  = prev_sz_reg + HDR + merged_sz;
                end else if (mnext) begin
                    fw_en  = 1'b1;
                    fw_idx = idx_reg[FA-1:0];
                    fw_off = noff;
                    fw_sz  = merged_sz;
                end
            end
            DP_RRD: begin
                fr_en  = 1'b1;
                fr_idx = FA'(k_reg + 1'b1);
            end
            DP_IRD: begin
                fr_en  = 1'b1;
                fr_idx = FA'(k_reg - 1'b1);
            end
            DP_RWR, DP_IWR: begin
                fw_en  = 1'b1;
                fw_idx = k_reg[FA-1:0];
                fw_off = rd_off_reg;
                fw_sz  = rd_sz_reg;
            end
            DP_IFIN: begin
                fw_en  = 1'b1;
                fw_idx = idx_reg[FA-1:0];
                fw_off = noff;
                fw_sz  = nsz_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (fw_en) begin
            free_off_mem[fw_idx] <= fw_off;
            free_sz_mem[fw_idx]  <= fw_sz;
        end
        if (fr_en) begin
            rd_off_reg <= free_off_mem[fr_idx];
            rd_sz_reg  <= free_sz_mem[fr_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd == DP_GRANT) begin
            used_off_mem[free_slot] <= pick_off_reg + HDR;
            used_sz_mem[free_slot]  <= grant;
        end
        if (cmd == DP_URD) begin
            ur_off_reg <= used_off_mem[j_reg[UA-1:0]];
            ur_sz_reg  <= used_sz_mem[j_reg[UA-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg    <= 1'b0;
            heap_reg      <= HEAP_RESET;
            init_pend_reg <= 1'b1;
            count_reg     <= CW'(1);
            valid_reg     <= '0;
        end else begin
            init_pend_reg <= 1'b0;
            if (cfg_wr_en && cfg_addr == CFG_POLICY) begin
                policy_reg <= cfg_wdata[0];
            end
            if (heap_wr) begin
                heap_reg      <= heap_val;
                init_pend_reg <= 1'b1;
                count_reg     <= CW'(1);
                valid_reg     <= '0;
            end else begin
                if (cmd == DP_GRANT) begin
                    valid_reg[free_slot] <= 1'b1;
                end
                if (cmd == DP_MERGE) begin
                    valid_reg[slot_reg] <= 1'b0;
                end
                if (cmd == DP_RDONE) begin
                    count_reg <= count_reg - 1'b1;
                end
                if (cmd == DP_IFIN) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd)
            DP_LOAD: begin
                op_reg       <= s_op;
                addr_reg     <= s_address;
                need_reg     <= need_in;
                idx_reg      <= '0;
                has_pick_reg <= 1'b0;
                best_reg     <= '1;
                j_reg        <= '0;
                next_vld_reg <= 1'b0;
            end
            DP_OK0, DP_FAIL1, DP_FAIL2, DP_FAIL3: begin
                res_addr_reg  <= '0;
                res_grant_reg <= '0;
                case (cmd)
                    DP_FAIL1: res_status_reg <= ST_NO_FIT;
                    DP_FAIL2: res_status_reg <= ST_FULL;
                    DP_FAIL3: res_status_reg <= ST_UNKNOWN;
                    default:  res_status_reg <= ST_OK;
                endcase
            end
            DP_FIT: begin
                if (fit && (!policy_reg || diff < best_reg)) begin
                    pick_idx_reg <= idx_reg[FA-1:0];
                    pick_off_reg <= rd_off_reg;
                    pick_sz_reg  <= rd_sz_reg;
                    has_pick_reg <= 1'b1;
                    best_reg     <= diff;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            DP_GRANT: begin
                res_status_reg <= ST_OK;
                res_addr_reg   <= pick_off_reg + HDR;
                res_grant_reg  <= grant;
                k_reg          <= CW'(pick_idx_reg);
            end
            DP_UCHK: begin
                if (valid_reg[j_reg[UA-1:0]] && ur_off_reg == addr_reg) begin
                    slot_reg <= j_reg[UA-1:0];
                    nsz_reg  <= ur_sz_reg;
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            DP_PCHK: begin
                if (noff_ok && rd_off_reg > noff) begin
                    next_vld_reg <= 1'b1;
                    next_off_reg <= rd_off_reg;
                    next_sz_reg  <= rd_sz_reg;
                end else begin
                    prev_off_reg <= rd_off_reg;
                    prev_sz_reg  <= rd_sz_reg;
                    idx_reg      <= idx_reg + 1'b1;
                end
            end
            DP_MERGE: begin
                res_status_reg <= ST_OK;
                res_addr_reg   <= '0;
                res_grant_reg  <= '0;
                // both neighbors merged: drop the upper one; no merge: open a hole
                k_reg <= (mnext && mprev) ? idx_reg : count_reg;
            end
            DP_RWR: k_reg <= k_reg + 1'b1;
            DP_IWR: k_reg <= k_reg - 1'b1;
            DP_OUT: begin
                out_status_reg <= res_status_reg;
                out_addr_reg   <= res_addr_reg;
                out_grant_reg  <= res_grant_reg;
            end
            default: ;
        endcase
    end

    assign m_status        = out_status_reg;
    assign m_address_out   = out_addr_reg;
    assign m_granted_bytes = out_grant_reg;

endmodule

// ----- rtl/free_list_heap_allocator.sv -----
// Top level of the free-list heap allocator.
// Heap bookkeeping by byte offsets: an allocate request takes the first or the
// best fitting free block and returns its payload offset, a free request gives
// a block back and merges it with its neighbors. One request is worked at a
// time. An allocate reads and compares the free-table entries one by one and
// shifts the later entries down when a block is used up; a free searches the
// used table entry by entry, scans the free table up to the insert point and
// shifts entries to close or open a slot. Each table memory has a single read
// port. After reset and after every heap_bytes write the block sets up the
// free table before it takes a request.
module free_list_heap_allocator #(
    parameter int FREE_SLOTS = fla_pkg::FREE_SLOTS_DEF,
    parameter int USED_SLOTS = fla_pkg::USED_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [31:0] s_request_bytes,
    input  logic [31:0] s_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_address_out,
    output logic [31:0] m_granted_bytes
);
    import fla_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    fla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fla_dp #(
        .FREE_SLOTS (FREE_SLOTS),
        .USED_SLOTS (USED_SLOTS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_op            (s_op),
        .s_request_bytes (s_request_bytes),
        .s_address       (s_address),
        .cmd             (cmd),
        .stat            (stat),
        .m_status        (m_status),
        .m_address_out   (m_address_out),
        .m_granted_bytes (m_granted_bytes)
    );

endmodule
